/* src/max_heap_priority_queue_assert.svh */
// Assertion macros used by the heap queue sift engine.
// Needs no other file; each macro is empty when SYNTHESIS is defined.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define MHPQ_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("heap queue check failed");
`define MHPQ_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("heap queue check failed");
`define MHPQ_ASSERT_NEVER(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("heap queue check failed");
`else
`define MHPQ_ASSERT_IMP(label, clk, rst, a, b)
`define MHPQ_ASSERT_NXT(label, clk, rst, a, b)
`define MHPQ_ASSERT_NEVER(label, clk, rst, a)
`endif
`endif

/* src/mhpq_pkg.sv */
// Shared types and constants for the max-heap priority queue.
// Used by the interfaces, the sift engine and the top level.
package mhpq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VALUE_W   = 32;
  localparam int FILL_W    = 7;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    logic                      pop_valid;
    logic [1:0]                status;
    logic [FILL_W-1:0]         fill_count;
  } mhpq_result_t;

endpackage

/* src/mhpq_if.sv */
// Valid/ready channels for requests into and results out of the heap queue.
// Depends on mhpq_pkg for the payload widths.
interface mhpq_req_if import mhpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] popped_value;
  logic                      pop_valid;
  logic [1:0]                status;
  logic [FILL_W-1:0]         fill_count;

  modport source (output valid, output popped_value, output pop_valid,
                  output status, output fill_count, input ready);
  modport sink (input valid, input popped_value, input pop_valid,
                input status, input fill_count, output ready);
endinterface

/* src/mhpq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Stands alone; no package needed.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mhpq_engine.sv */
// Sift engine: runs push (sift up) and pop (sift down) over the heap RAM.
// Depends on mhpq_pkg and the assertion macros header.
`include "max_heap_priority_queue_assert.svh"

module mhpq_engine import mhpq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_cmd,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      done_valid,
  input  logic                      done_ack,
  output mhpq_result_t              result,
  output logic                      mem_we,
  output logic [$clog2(DEPTH)-1:0]  mem_waddr,
  output logic [VALUE_W-1:0]        mem_wdata,
  output logic [$clog2(DEPTH)-1:0]  mem_raddr,
  input  logic [VALUE_W-1:0]        mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = AW + 2;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_CMP   = 4'd1;
  localparam logic [3:0] S_FINAL    = 4'd2;
  localparam logic [3:0] S_POP_TOP  = 4'd3;
  localparam logic [3:0] S_POP_LAST = 4'd4;
  localparam logic [3:0] S_DN_L     = 4'd5;
  localparam logic [3:0] S_DN_R     = 4'd6;
  localparam logic [3:0] S_DN_CMP   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]                state, state_next;
  logic [CW-1:0]             count, count_next;
  logic [AW-1:0]             pos, pos_next;
  logic signed [VALUE_W-1:0] v, v_next;
  logic signed [VALUE_W-1:0] lval, lval_next;
  logic signed [VALUE_W-1:0] res_popped, res_popped_next;
  logic                      res_valid, res_valid_next;
  logic [1:0]                res_status, res_status_next;

  logic                      in_fire;
  logic signed [VALUE_W-1:0] rd;
  logic [AW-1:0]             parent;
  logic [LW-1:0]             left, right, n_ext;
  logic                      has_right;
  logic                      take_right;
  logic signed [VALUE_W-1:0] pick_val;
  logic [AW-1:0]             pick;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign done_valid = (state == S_DONE);
  assign rd         = $signed(mem_rdata);

  assign parent     = (pos - AW'(1)) >> 1;
  assign left       = {1'b0, pos, 1'b0} + LW'(1);
  assign right      = left + LW'(1);
  assign n_ext      = LW'(count);
  assign has_right  = (right < n_ext);
  assign take_right = has_right && (rd > lval);
  assign pick_val   = take_right ? rd : lval;
  assign pick       = take_right ? right[AW-1:0] : left[AW-1:0];

  assign result.popped_value = res_popped;
  assign result.pop_valid    = res_valid;
  assign result.status       = res_status;
  assign result.fill_count   = FILL_W'(count);

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    v_next          = v;
    lval_next       = lval;
    res_popped_next = res_popped;
    res_valid_next  = res_valid;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = pos;
    mem_wdata       = v;
    mem_raddr       = parent;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          res_popped_next = '0;
          res_valid_next  = 1'b0;
          res_status_next = ST_OK;
          if (in_cmd == CMD_PUSH) begin
            if (count == FULL_COUNT) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else if (count == '0) begin
              mem_we     = 1'b1;
              mem_waddr  = '0;
              mem_wdata  = in_value;
              count_next = count + CW'(1);
              state_next = S_DONE;
            end else begin
              // Parent of the new slot is read now, compared next cycle.
              pos_next   = AW'(count);
              v_next     = in_value;
              mem_raddr  = AW'((count - CW'(1)) >> 1);
              count_next = count + CW'(1);
              state_next = S_UP_CMP;
            end
          end else begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              mem_raddr  = '0;
              state_next = S_POP_TOP;
            end
          end
        end
      end
      S_UP_CMP: begin
        if (rd >= v) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = rd;
          pos_next  = parent;
          mem_raddr = (parent - AW'(1)) >> 1;
          if (parent == '0) begin
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        mem_we     = 1'b1;
        state_next = S_DONE;
      end
      S_POP_TOP: begin
        res_popped_next = rd;
        res_valid_next  = 1'b1;
        mem_raddr       = AW'(count - CW'(1));
        state_next      = S_POP_LAST;
      end
      S_POP_LAST: begin
        v_next     = rd;
        pos_next   = '0;
        count_next = count - CW'(1);
        state_next = (count == CW'(1)) ? S_DONE : S_DN_L;
      end
      S_DN_L: begin
        if (left >= n_ext) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_raddr  = left[AW-1:0];
          state_next = S_DN_R;
        end
      end
      S_DN_R: begin
        lval_next  = rd;
        mem_raddr  = right[AW-1:0];
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (pick_val <= v) begin
          state_next = S_DONE;
        end else begin
          mem_wdata  = pick_val;
          pos_next   = pick;
          state_next = S_DN_L;
        end
      end
      S_DONE: begin
        if (done_ack) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    pos        <= pos_next;
    v          <= v_next;
    lval       <= lval_next;
    res_popped <= res_popped_next;
    res_valid  <= res_valid_next;
    res_status <= res_status_next;
  end

  `MHPQ_ASSERT_NEVER(a_count_range, clk, rst, count > FULL_COUNT)
  `MHPQ_ASSERT_IMP(a_write_in_range, clk, rst, mem_we, 32'(mem_waddr) < DEPTH)
  `MHPQ_ASSERT_NXT(a_full_push_holds, clk, rst,
    in_fire && in_cmd == CMD_PUSH && count == FULL_COUNT, count == FULL_COUNT)
  `MHPQ_ASSERT_IMP(a_pop_ok, clk, rst, done_valid && res_valid, res_status == ST_OK)

endmodule

/* src/max_heap_priority_queue.sv */
// Binary max-heap priority queue of up to DEPTH signed 32-bit values held in
// one RAM with a registered read. One request is worked at a time. A push
// climbs the new value toward the root one level at a time. A pop reads the
// top, then the last entry, and sinks that entry one level at a time (left
// child read, right child read, compare and write). The pace of both is set
// by the single read port of the heap RAM. Rejected requests go straight to
// the result. The result sits in an output register, so the next request is
// taken while it waits. No clearing pass follows reset: only the contents of
// filled entries are ever used.
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);

  logic               done_valid;
  logic               done_ack;
  mhpq_result_t       result;
  mhpq_result_t       out_data;
  logic               out_valid;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  mhpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mhpq_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_cmd     (req.cmd),
    .in_value   (req.value),
    .done_valid (done_valid),
    .done_ack   (done_ack),
    .result     (result),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // The output register takes a finished result whenever it is free or
  // being emptied in the same cycle.
  assign done_ack = done_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_ack) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (done_ack) begin
      out_data <= result;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.popped_value = out_data.popped_value;
  assign rsp.pop_valid    = out_data.pop_valid;
  assign rsp.status       = out_data.status;
  assign rsp.fill_count   = out_data.fill_count;

endmodule
